// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define PCS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define PCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pcs_pkg.sv =====
// Shared types and constants of the fixed-point PID step block.
// No dependencies; used by every module of the block.
`default_nettype none

package pcs_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int DT_W        = 16;
  localparam int GAIN_W      = 16;
  localparam int SAMPLE_FRAC = 8;
  localparam int DT_FRAC     = 16;
  localparam int GAIN_FRAC   = 8;
  localparam int OUT_FRAC    = 14;

  localparam int ERR_W       = SAMPLE_W + 1;
  localparam int DIFF_W      = ERR_W + 1;
  localparam int INTEG_W     = 24;
  localparam int INTEG_SUM_W = INTEG_W + 2;
  localparam int QUOT_W      = DIFF_W - 1 + DT_FRAC;
  localparam int DERIV_W     = QUOT_W + 1;
  localparam int DIV_STEPS   = QUOT_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int DLO_W       = 17;
  localparam int MUL_A_W     = 25;
  localparam int MUL_B_W     = GAIN_W + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int ACC_W       = 60;
  localparam int DRIVE_W     = 16;

  localparam int ALIGN_SHIFT = DT_FRAC - SAMPLE_FRAC;
  localparam int DHI_SHIFT   = ALIGN_SHIFT + DLO_W;
  localparam int OUT_SHIFT   = GAIN_FRAC + DT_FRAC - OUT_FRAC;

  localparam logic signed [INTEG_SUM_W-1:0] INTEG_MAX = INTEG_SUM_W'(100 * 65536);
  localparam logic signed [INTEG_SUM_W-1:0] INTEG_MIN = -INTEG_SUM_W'(100 * 65536);
  localparam logic signed [ACC_W-1:0] ACC_ONE     = ACC_W'(1) <<< (GAIN_FRAC + DT_FRAC);
  localparam logic signed [ACC_W-1:0] ACC_NEG_ONE = -ACC_ONE;
  localparam logic signed [DRIVE_W-1:0] DRIVE_POS = DRIVE_W'(16384);
  localparam logic signed [DRIVE_W-1:0] DRIVE_NEG = -DRIVE_W'(16384);

  localparam logic signed [SAMPLE_W-1:0] TARGET_RST = '0;
  localparam logic [GAIN_W-1:0] GAIN_P_RST = GAIN_W'(512);
  localparam logic [GAIN_W-1:0] GAIN_I_RST = GAIN_W'(128);
  localparam logic [GAIN_W-1:0] GAIN_D_RST = GAIN_W'(256);

  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_GAIN_P = 2'd1,
    REG_GAIN_I = 2'd2,
    REG_GAIN_D = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    MSEL_ERR_DT,
    MSEL_P,
    MSEL_I,
    MSEL_DLO,
    MSEL_DHI
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_P,
    ACC_ADD_I,
    ACC_ADD_DLO,
    ACC_ADD_DHI
  } acc_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INC,
    ST_INTEG,
    ST_MUL_I,
    ST_ACC_I,
    ST_WAIT_DIV,
    ST_MUL_DLO,
    ST_MUL_DHI,
    ST_ACC_DHI,
    ST_RESULT,
    ST_CLEAR
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_FIX
  } div_state_t;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     integ_upd;
    acc_op_t  acc_op;
    logic     out_load;
    logic     out_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/pcs_ctrl.sv =====
// Sequencer of the PID step: handshakes and datapath commands.
// Depends on pcs_pkg.
`default_nettype none

module pcs_ctrl import pcs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  input  wire opcode_t    op,
  output logic            s_tready,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t state, state_next;
  logic out_free;

  // output register can take a new result this cycle
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = MSEL_ERR_DT;
    cmd.acc_op  = ACC_HOLD;
    s_tready    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (op == OP_CLEAR) begin
            cmd.clear  = 1'b1;
            state_next = ST_CLEAR;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_INC;
          end
        end
      end
      ST_INC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_ERR_DT;
        state_next  = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MSEL_P;
        state_next    = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.acc_op  = ACC_LOAD_P;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_I;
        state_next  = ST_ACC_I;
      end
      ST_ACC_I: begin
        cmd.acc_op = ACC_ADD_I;
        state_next = ST_WAIT_DIV;
      end
      ST_WAIT_DIV: begin
        if (status.div_done) begin
          state_next = ST_MUL_DLO;
        end
      end
      ST_MUL_DLO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_DLO;
        state_next  = ST_MUL_DHI;
      end
      ST_MUL_DHI: begin
        cmd.acc_op  = ACC_ADD_DLO;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_DHI;
        state_next  = ST_ACC_DHI;
      end
      ST_ACC_DHI: begin
        cmd.acc_op = ACC_ADD_DHI;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_zero = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/pcs_div.sv =====
// Radix-2 restoring divider for the derivative term, one quotient bit a cycle.
// Depends on pcs_pkg.
`default_nettype none

module pcs_div import pcs_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic                      neg,
  input  wire logic [DIFF_W-2:0]         mag,
  input  wire logic [DT_W-1:0]           divisor,
  output logic signed [DERIV_W-1:0]      quot,
  output logic                           done
);

  div_state_t state, state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DT_W-1:0] rem, dvs, rem_step;
  logic [QUOT_W-1:0] nq;
  logic neg_r;
  logic [DT_W:0] trial;
  logic ge;
  logic signed [DERIV_W-1:0] qext;

  assign trial = {rem, nq[QUOT_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign qext  = $signed({1'b0, nq});

  always_comb begin
    rem_step = trial[DT_W-1:0];
    if (ge) begin
      rem_step = DT_W'(trial - {1'b0, dvs});
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      DV_IDLE: begin
        if (start) begin
          state_next = DV_RUN;
        end
      end
      DV_RUN: begin
        if (cnt == DIV_CNT_W'(1)) begin
          state_next = DV_FIX;
        end
      end
      DV_FIX: begin
        state_next = DV_IDLE;
      end
      default: begin
        state_next = DV_IDLE;
      end
    endcase
    if (start) begin
      state_next = DV_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      if (start) begin
        cnt  <= DIV_CNT_W'(DIV_STEPS);
        done <= 1'b0;
      end else if (state == DV_RUN) begin
        cnt <= cnt - DIV_CNT_W'(1);
      end else if (state == DV_FIX) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      nq    <= {mag, {DT_FRAC{1'b0}}};
      dvs   <= divisor;
      neg_r <= neg;
    end else if (state == DV_RUN) begin
      rem <= rem_step;
      nq  <= {nq[QUOT_W-2:0], ge};
    end
    if (state == DV_FIX) begin
      quot <= neg_r ? -qext : qext;
    end
  end

endmodule

`default_nettype wire

// ===== src/pcs_datapath.sv =====
// Datapath of the PID step: config registers, state, shared multiplier,
// accumulator, saturation and result register. Depends on pcs_pkg, pcs_div.
`default_nettype none

module pcs_datapath import pcs_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire cfg_reg_t               cfg_index,
  input  wire logic [GAIN_W-1:0]      cfg_data,
  input  wire logic [SAMPLE_W-1:0]    measured,
  input  wire logic [DT_W-1:0]        step_time,
  input  wire dp_cmd_t                cmd,
  output dp_status_t                  status,
  output logic [DRIVE_W-1:0]          drive,
  output logic                        drive_saturated,
  output logic                        integral_clamped
);

  logic signed [SAMPLE_W-1:0] target_value;
  logic [GAIN_W-1:0] gain_p, gain_i, gain_d;

  logic signed [ERR_W-1:0] err_next, err, last_error;
  logic signed [DIFF_W-1:0] diff_next;
  logic [DIFF_W-2:0] diff_abs;
  logic [DT_W-1:0] dt, divisor;
  logic signed [INTEG_W-1:0] error_integral;
  logic signed [INTEG_SUM_W-1:0] inc, integ_sum, integ_clip;
  logic iclamp_next, iclamp;
  logic signed [DERIV_W-1:0] deriv;
  logic div_done;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc, prod_ext;
  logic signed [DRIVE_W-1:0] drive_val;
  logic sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_value <= TARGET_RST;
      gain_p       <= GAIN_P_RST;
      gain_i       <= GAIN_I_RST;
      gain_d       <= GAIN_D_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TARGET: target_value <= $signed(cfg_data);
        REG_GAIN_P: gain_p <= cfg_data;
        REG_GAIN_I: gain_i <= cfg_data;
        REG_GAIN_D: gain_d <= cfg_data;
        default: ;
      endcase
    end
  end

  assign err_next  = ERR_W'(target_value) - ERR_W'($signed(measured));
  assign diff_next = DIFF_W'(err_next) - DIFF_W'(last_error);
  // magnitude of the difference always fits one bit narrower
  assign diff_abs  = diff_next[DIFF_W-1] ? (DIFF_W-1)'(-diff_next)
                                         : (DIFF_W-1)'(diff_next);
  // a zero step time divides by one
  assign divisor   = (step_time == '0) ? DT_W'(1) : step_time;

  pcs_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.load),
    .neg     (diff_next[DIFF_W-1]),
    .mag     (diff_abs),
    .divisor (divisor),
    .quot    (deriv),
    .done    (div_done)
  );

  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err <= err_next;
      dt  <= step_time;
    end
  end

  // error*dt from Q8.24 down to Q8.16, floor
  assign inc       = $signed(prod[SAMPLE_FRAC+INTEG_SUM_W-1:SAMPLE_FRAC]);
  assign integ_sum = INTEG_SUM_W'(error_integral) + inc;

  always_comb begin
    integ_clip  = integ_sum;
    iclamp_next = 1'b0;
    if (integ_sum > INTEG_MAX) begin
      integ_clip  = INTEG_MAX;
      iclamp_next = 1'b1;
    end else if (integ_sum < INTEG_MIN) begin
      integ_clip  = INTEG_MIN;
      iclamp_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_integral <= '0;
      last_error     <= '0;
    end else begin
      if (cmd.clear) begin
        error_integral <= '0;
        last_error     <= '0;
      end else begin
        if (cmd.load) begin
          last_error <= err_next;
        end
        if (cmd.integ_upd) begin
          error_integral <= INTEG_W'(integ_clip);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.integ_upd) begin
      iclamp <= iclamp_next;
    end
  end

  // shared multiplier; derivative term in two halves
  always_comb begin
    mul_a = MUL_A_W'(err);
    mul_b = $signed({1'b0, dt});
    case (cmd.mul_sel)
      MSEL_ERR_DT: begin
        mul_a = MUL_A_W'(err);
        mul_b = $signed({1'b0, dt});
      end
      MSEL_P: begin
        mul_a = MUL_A_W'(err);
        mul_b = $signed({1'b0, gain_p});
      end
      MSEL_I: begin
        mul_a = MUL_A_W'(error_integral);
        mul_b = $signed({1'b0, gain_i});
      end
      MSEL_DLO: begin
        mul_a = $signed({{(MUL_A_W-DLO_W){1'b0}}, deriv[DLO_W-1:0]});
        mul_b = $signed({1'b0, gain_d});
      end
      MSEL_DHI: begin
        mul_a = MUL_A_W'($signed(deriv[DERIV_W-1:DLO_W]));
        mul_b = $signed({1'b0, gain_d});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      ACC_LOAD_P:  acc <= prod_ext <<< ALIGN_SHIFT;
      ACC_ADD_I:   acc <= acc + prod_ext;
      ACC_ADD_DLO: acc <= acc + (prod_ext <<< ALIGN_SHIFT);
      ACC_ADD_DHI: acc <= acc + (prod_ext <<< DHI_SHIFT);
      default: ;
    endcase
  end

  always_comb begin
    drive_val = $signed(acc[OUT_SHIFT+DRIVE_W-1:OUT_SHIFT]);
    sat       = 1'b0;
    if (acc > ACC_ONE) begin
      drive_val = DRIVE_POS;
      sat       = 1'b1;
    end else if (acc < ACC_NEG_ONE) begin
      drive_val = DRIVE_NEG;
      sat       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_zero) begin
        drive            <= '0;
        drive_saturated  <= 1'b0;
        integral_clamped <= 1'b0;
      end else begin
        drive            <= drive_val;
        drive_saturated  <= sat;
        integral_clamped <= iclamp;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/pid_controller_step.sv =====
// Fixed-point PID step. One item is worked on at a time, so the sustained
// rate of step items is set by the serial divider of the derivative term
// (33 quotient bits and a sign fix). The result register lets the next item
// in while a result waits. Synchronous reset restores setpoint 0, gains
// 2.0/0.5/1.0, zero integral and last error, and an empty output.
`default_nettype none

module pid_controller_step import pcs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] measured, [31:16] step_time
  input  wire logic [0:0]  s_tuser,   // [0] opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [15:0] drive
  output logic [1:0]       m_tuser,   // [0] drive_saturated, [1] integral_clamped
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (opcode_t'(s_tuser[0])),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pcs_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_reg_t'(cfg_index)),
    .cfg_data         (cfg_data),
    .measured         (s_tdata[15:0]),
    .step_time        (s_tdata[31:16]),
    .cmd              (cmd),
    .status           (status),
    .drive            (m_tdata),
    .drive_saturated  (m_tuser[0]),
    .integral_clamped (m_tuser[1])
  );

endmodule

`default_nettype wire

// ===== src/pcs_checker.sv =====
// Port-level checks for the PID step block, bound to the top level.
// Depends on assert_macros.svh and pid_controller_step.
`default_nettype none
`include "assert_macros.svh"

module pcs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // stalled result holds
  `PCS_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // one item in flight: input closes right after an accept
  `PCS_ASSERT(a_one_item, clk, rst, s_tvalid && s_tready |=> !s_tready, "input open while item in work")

  // drive stays within -1.0 .. +1.0
  `PCS_ASSERT(a_drive_range, clk, rst, m_tvalid |-> ($signed(m_tdata) <= 16'sd16384 && $signed(m_tdata) >= -16'sd16384), "drive out of range")

  // saturated drive sits at a rail
  `PCS_ASSERT(a_sat_rail, clk, rst, m_tvalid && m_tuser[0] |-> (m_tdata == 16'h4000 || m_tdata == 16'hC000), "saturated drive off rail")

  // reset empties the output
  `PCS_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind pid_controller_step pcs_checker u_pcs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== dv/pid_controller_step_tb.sv =====
// Self-checking testbench for pid_controller_step: drives step and clear items
// over the stream ports and checks every result against an in-bench PID model.
// Depends on pcs_pkg and the pid_controller_step RTL only.
module pid_controller_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcs_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 130;

  typedef struct packed {
    opcode_t     op;
    logic [15:0] measured;
    logic [15:0] step_time;
  } pid_cmd_t;

  typedef struct packed {
    logic [15:0] drive;
    logic        drive_saturated;
    logic        integral_clamped;
  } pid_result_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;  // [15:0] measured, [31:16] step_time
  logic [0:0]  s_tuser   = '0;  // [0] opcode
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;         // [15:0] drive
  logic [1:0]  m_tuser;         // [0] drive_saturated, [1] integral_clamped
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  // model state and register copies
  longint setpoint = 0;
  longint kp = GAIN_P_RST;
  longint ki = GAIN_I_RST;
  longint kd = GAIN_D_RST;
  longint integ_acc = 0;
  longint prev_err = 0;

  pid_result_t drive_expect_q[$];
  pid_result_t drive_got, drive_want;
  int fail_count = 0;
  int rx_wait = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;  // no idling on either side

  pid_controller_step u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic pid_result_t pid_predict(pid_cmd_t cmd);
    pid_result_t r;
    longint err, dt, integ, deriv, acc, drv;
    longint ilim, one;
    ilim = longint'(100) <<< DT_FRAC;
    one  = longint'(1) <<< (GAIN_FRAC + DT_FRAC);
    r = '0;
    if (cmd.op == OP_CLEAR) begin
      integ_acc = 0;
      prev_err  = 0;
      return r;
    end
    err = setpoint - longint'($signed(cmd.measured));
    dt  = longint'(cmd.step_time);
    integ = integ_acc + ((err * dt) >>> SAMPLE_FRAC);
    if (integ > ilim) begin
      integ = ilim;
      r.integral_clamped = 1'b1;
    end else if (integ < -ilim) begin
      integ = -ilim;
      r.integral_clamped = 1'b1;
    end
    // signed division truncates toward zero; zero dt divides by one
    deriv = ((err - prev_err) <<< DT_FRAC) / ((dt != 0) ? dt : 1);
    acc = kp * err * (longint'(1) <<< ALIGN_SHIFT) + ki * integ
        + kd * deriv * (longint'(1) <<< ALIGN_SHIFT);
    if (acc > one) begin
      acc = one;
      r.drive_saturated = 1'b1;
    end else if (acc < -one) begin
      acc = -one;
      r.drive_saturated = 1'b1;
    end
    drv = acc >>> OUT_SHIFT;
    r.drive = drv[15:0];
    integ_acc = integ;
    prev_err  = err;
    return r;
  endfunction

  function automatic pid_cmd_t step_cmd(logic [15:0] meas, logic [15:0] dt);
    pid_cmd_t c;
    c.op = OP_STEP;
    c.measured = meas;
    c.step_time = dt;
    return c;
  endfunction

  function automatic pid_cmd_t clear_cmd();
    pid_cmd_t c;
    c.op = OP_CLEAR;
    c.measured = 16'($urandom);
    c.step_time = 16'($urandom);
    return c;
  endfunction

  // valid stays high from one item to the next when no gap is drawn
  task automatic send_item(input pid_cmd_t cmd);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {cmd.step_time, cmd.measured};
    s_tuser  <= cmd.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    drive_expect_q.push_back(pid_predict(cmd));
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (drive_expect_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_TARGET: setpoint = longint'($signed(val));
      REG_GAIN_P: kp = longint'(val);
      REG_GAIN_I: ki = longint'(val);
      REG_GAIN_D: kd = longint'(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] tgt, input logic [15:0] p,
                            input logic [15:0] i, input logic [15:0] d);
    wait_results();
    write_reg(REG_TARGET, tgt);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
  endtask

  // reset gains: sample extremes, integral clamp, zero dt, clears
  task automatic test_reset_defaults();
    send_item(step_cmd(16'h0000, 16'h0001));
    send_item(step_cmd(16'h0100, 16'h0100));
    send_item(step_cmd(16'h7FFF, 16'hFFFF));
    send_item(step_cmd(16'h8000, 16'hFFFF));
    send_item(step_cmd(16'h8000, 16'hFFFF));
    send_item(step_cmd(16'h7FFF, 16'h0001));
    send_item(step_cmd(16'h0000, 16'h0000));
    send_item(clear_cmd());
    send_item(step_cmd(16'h0010, 16'h0400));
    send_item(clear_cmd());
    send_item(clear_cmd());
  endtask

  task automatic test_config_extremes();
    set_config(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(step_cmd(16'h8000, 16'hFFFF));
    send_item(step_cmd(16'h7FFF, 16'h0001));
    send_item(step_cmd(16'h7FFF, 16'h0000));
    set_config(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_item(step_cmd(16'h7FFF, 16'hFFFF));
    send_item(step_cmd(16'h8000, 16'h0001));
    send_item(clear_cmd());
    set_config(16'h0000, 16'h0001, 16'h0001, 16'h0001);
    send_item(step_cmd(16'hFFFF, 16'h8000));
    send_item(step_cmd(16'h0001, 16'h0001));
    send_item(step_cmd(16'h0000, 16'hFFFF));
  endtask

  function automatic logic [15:0] draw_gain();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
  endfunction

  // mostly measurements close to the setpoint so the loop stays out of
  // saturation, the rest full-range noise
  task automatic test_random_phases();
    int ph, n, r, delta;
    logic [15:0] meas, dt;
    for (ph = 0; ph < PHASES; ph++) begin
      steady = (ph == PHASES - 3);
      set_config(16'($urandom), draw_gain(), draw_gain(), draw_gain());
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        delta = $urandom_range(0, 1023) - 512;
        meas = (r < 70) ? 16'(setpoint + delta) : 16'($urandom);
        dt = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
                                  : 16'($urandom_range(1, 4096));
        if (r < 5) send_item(clear_cmd());
        else send_item(step_cmd(meas, dt));
        if ($urandom_range(0, 49) == 0) wait_results();
      end
    end
    steady = 1'b0;
  endtask

  // result checker with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        drive_got = {m_tdata, m_tuser[0], m_tuser[1]};
        if (drive_expect_q.size() == 0) begin
          $error("unexpected result: drive %0d", $signed(m_tdata));
          fail_count++;
        end else begin
          drive_want = drive_expect_q.pop_front();
          if (drive_got.drive !== drive_want.drive) begin
            $error("drive: expected %0d, got %0d",
                   $signed(drive_want.drive), $signed(drive_got.drive));
            fail_count++;
          end
          if (drive_got.drive_saturated !== drive_want.drive_saturated) begin
            $error("drive_saturated: expected %0b, got %0b",
                   drive_want.drive_saturated, drive_got.drive_saturated);
            fail_count++;
          end
          if (drive_got.integral_clamped !== drive_want.integral_clamped) begin
            $error("integral_clamped: expected %0b, got %0b",
                   drive_want.integral_clamped, drive_got.integral_clamped);
            fail_count++;
          end
        end
        rx_wait = draw_gap();
      end
      if (rx_wait != 0) begin
        m_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_random_phases();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && drive_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
